FILE: design/itrs_pkg.sv
// Shared types, constants, microcode table and helper functions for the
// integer_to_radix_string block. No dependencies.
package itrs_pkg;

  localparam int DEF_WORD_BITS = 32;
  localparam int STEP_BITS     = 8;

  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] RADIX_MIN   = 6'd2;
  localparam logic [5:0] RADIX_MAX   = 6'd36;
  localparam logic [5:0] RADIX_DEC   = 6'd10;
  localparam logic [5:0] DIGIT_MAX   = 6'd9;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LETTER = 8'h61;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  // datapath operations
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_DIV   = 3'd2;
  localparam logic [2:0] OP_STORE = 3'd3;
  localparam logic [2:0] OP_SIGN  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;
  localparam logic [2:0] OP_EMIT  = 3'd6;

  // wait kinds: hold the step until the handshake side is ready
  localparam logic [1:0] WT_NONE = 2'd0;
  localparam logic [1:0] WT_IN   = 2'd1;
  localparam logic [1:0] WT_OUT  = 2'd2;

  // jump conditions
  localparam logic [2:0] C_NEVER      = 3'd0;
  localparam logic [2:0] C_ALWAYS     = 3'd1;
  localparam logic [2:0] C_CHUNK_MORE = 3'd2;
  localparam logic [2:0] C_DIGIT_MORE = 3'd3;
  localparam logic [2:0] C_NOT_NEG    = 3'd4;
  localparam logic [2:0] C_CHAR_MORE  = 3'd5;

  // program steps
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_STORE = 3'd2;
  localparam logic [2:0] ST_TEST  = 3'd3;
  localparam logic [2:0] ST_SIGN  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam int PROG_LEN = 8;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] wt;
    logic [2:0] cond;
    logic [2:0] target;
  } ucode_t;

  localparam ucode_t UCODE [PROG_LEN] = '{
    '{op: OP_LOAD,  wt: WT_IN,   cond: C_NEVER,      target: ST_IDLE},
    '{op: OP_DIV,   wt: WT_NONE, cond: C_CHUNK_MORE, target: ST_DIV},
    '{op: OP_STORE, wt: WT_NONE, cond: C_DIGIT_MORE, target: ST_DIV},
    '{op: OP_NOP,   wt: WT_NONE, cond: C_NOT_NEG,    target: ST_READ},
    '{op: OP_SIGN,  wt: WT_OUT,  cond: C_NEVER,      target: ST_IDLE},
    '{op: OP_READ,  wt: WT_NONE, cond: C_NEVER,      target: ST_IDLE},
    '{op: OP_EMIT,  wt: WT_OUT,  cond: C_CHAR_MORE,  target: ST_READ},
    '{op: OP_NOP,   wt: WT_NONE, cond: C_ALWAYS,     target: ST_IDLE}
  };

  typedef struct packed {
    logic in_ready;
    logic [2:0] op;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic chunk_more;
    logic digit_more;
    logic neg;
    logic char_more;
  } stat_t;

  typedef struct packed {
    logic [5:0] rem;
    logic [7:0] quo;
  } div_res_t;

  // Long division of one byte by the radix, carrying the running remainder.
  function automatic div_res_t div_chunk(input logic [5:0] rem_in, input logic [7:0] bits,
                                         input logic [5:0] rdx);
    logic [6:0] acc;
    div_res_t res;
    acc = {1'b0, rem_in};
    res.quo = '0;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[5:0], bits[i]};
      if (acc >= {1'b0, rdx}) begin
        acc = acc - {1'b0, rdx};
        res.quo[i] = 1'b1;
      end
    end
    res.rem = acc[5:0];
    return res;
  endfunction

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] ch;
    if (d > DIGIT_MAX) begin
      ch = {2'b00, d - 6'd10} + CH_LETTER;
    end else begin
      ch = {2'b00, d} + CH_ZERO;
    end
    return ch;
  endfunction

endpackage

FILE: design/itrs_seq.sv
// Microcode sequencer: step counter, control ROM from itrs_pkg, wait and
// jump evaluation. Depends on itrs_pkg.
module itrs_seq (
  input  logic            clk,
  input  logic            rst,
  input  itrs_pkg::stat_t stat,
  output itrs_pkg::ctrl_t ctrl
);

  logic [2:0] pc;
  logic [2:0] pc_next;
  itrs_pkg::ucode_t uw;
  logic stall;
  logic take;

  always_comb begin
    uw = itrs_pkg::UCODE[pc];
    stall = ((uw.wt == itrs_pkg::WT_IN) && !stat.in_valid) ||
            ((uw.wt == itrs_pkg::WT_OUT) && !stat.out_free);
    case (uw.cond)
      itrs_pkg::C_NEVER:      take = 1'b0;
      itrs_pkg::C_ALWAYS:     take = 1'b1;
      itrs_pkg::C_CHUNK_MORE: take = stat.chunk_more;
      itrs_pkg::C_DIGIT_MORE: take = stat.digit_more;
      itrs_pkg::C_NOT_NEG:    take = !stat.neg;
      itrs_pkg::C_CHAR_MORE:  take = stat.char_more;
      default:                take = 1'b0;
    endcase
    if (stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + 3'd1;
    end
    ctrl.in_ready = (uw.wt == itrs_pkg::WT_IN);
    ctrl.op = stall ? itrs_pkg::OP_NOP : uw.op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= itrs_pkg::ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: design/itrs_datapath.sv
// Datapath: working quotient, byte-wide radix divider, digit memory and
// output register, all driven by the sequencer's op code. Depends on itrs_pkg.
module itrs_datapath #(
  parameter int WORD_BITS = itrs_pkg::DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  itrs_pkg::ctrl_t      ctrl,
  input  logic [5:0]           radix,
  input  logic                 in_valid,
  input  logic [WORD_BITS-1:0] in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_char,
  output logic                 out_last,
  output itrs_pkg::stat_t      stat
);

  localparam int CHUNKS = (WORD_BITS + itrs_pkg::STEP_BITS - 1) / itrs_pkg::STEP_BITS;
  localparam int QW     = CHUNKS * itrs_pkg::STEP_BITS;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int IW     = $clog2(WORD_BITS);
  localparam int CNTW   = $clog2(WORD_BITS + 1);

  logic [QW-1:0]        work;
  logic [5:0]           rem;
  logic [CW-1:0]        chunk;
  logic [CNTW-1:0]      count;
  logic                 neg;
  logic [5:0]           rdata;
  logic [5:0]           mem [WORD_BITS];
  logic [WORD_BITS-1:0] mag;
  logic                 is_neg;
  logic                 out_free;
  itrs_pkg::div_res_t   dres;

  always_comb begin
    is_neg = (radix == itrs_pkg::RADIX_DEC) && in_value[WORD_BITS-1];
    mag = is_neg ? (~in_value + WORD_BITS'(1)) : in_value;
    dres = itrs_pkg::div_chunk(rem, work[QW-1 -: itrs_pkg::STEP_BITS], radix);
    out_free = !out_valid || out_ready;
    stat.in_valid   = in_valid;
    stat.out_free   = out_free;
    stat.chunk_more = (chunk != CW'(CHUNKS - 1));
    stat.digit_more = (work != '0) && (count < CNTW'(WORD_BITS - 1));
    stat.neg        = neg;
    stat.char_more  = (count != CNTW'(1));
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= '0;
      count <= '0;
      neg   <= 1'b0;
    end else begin
      case (ctrl.op)
        itrs_pkg::OP_LOAD: begin
          work  <= QW'(mag);
          rem   <= '0;
          chunk <= '0;
          count <= '0;
          neg   <= is_neg;
        end
        itrs_pkg::OP_DIV: begin
          work  <= (work << itrs_pkg::STEP_BITS) | QW'(dres.quo);
          rem   <= dres.rem;
          chunk <= (chunk == CW'(CHUNKS - 1)) ? '0 : chunk + CW'(1);
        end
        itrs_pkg::OP_STORE: begin
          rem   <= '0;
          count <= count + CNTW'(1);
        end
        itrs_pkg::OP_EMIT: begin
          count <= count - CNTW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // digit memory, least significant digit first
  always_ff @(posedge clk) begin
    if (ctrl.op == itrs_pkg::OP_STORE) begin
      mem[count[IW-1:0]] <= rem;
    end
    if (ctrl.op == itrs_pkg::OP_READ) begin
      rdata <= mem[IW'(count - CNTW'(1))];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((ctrl.op == itrs_pkg::OP_SIGN) || (ctrl.op == itrs_pkg::OP_EMIT)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == itrs_pkg::OP_SIGN) begin
      out_char <= itrs_pkg::CH_MINUS;
      out_last <= 1'b0;
    end else if (ctrl.op == itrs_pkg::OP_EMIT) begin
      out_char <= itrs_pkg::digit_char(rdata);
      out_last <= (count == CNTW'(1));
    end
  end

endmodule

FILE: design/integer_to_radix_string.sv
// Integer to text in a base from 2 to 36, most significant character first.
// Digits come from repeated byte-wide division of the working quotient by the radix,
// carrying the remainder from byte to byte; one item at a time.
// Synchronous active-high reset: sequencer to idle, radix to 10, output empty.
module integer_to_radix_string #(
  parameter int WORD_BITS = itrs_pkg::DEF_WORD_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data,        // radix
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  // value [WORD_BITS-1:0], zero padding above
  input  logic [((WORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,    // text_char [7:0]
  output logic       m_axis_tlast
);

  logic [5:0]      radix;
  logic [5:0]      radix_next;
  itrs_pkg::ctrl_t ctrl;
  itrs_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    radix_next = cfg_data;
    if (cfg_data < itrs_pkg::RADIX_MIN) begin
      radix_next = itrs_pkg::RADIX_MIN;
    end else if (cfg_data > itrs_pkg::RADIX_MAX) begin
      radix_next = itrs_pkg::RADIX_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itrs_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= radix_next;
    end
  end

  assign s_axis_tready = ctrl.in_ready;

  itrs_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  itrs_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .radix     (radix),
    .in_valid  (s_axis_tvalid),
    .in_value  (s_axis_tdata[WORD_BITS-1:0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_char  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .stat      (stat)
  );

  // leave idle right after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken twice in a row");

  a_radix_range: assert property (@(posedge clk) disable iff (rst)
    (radix >= itrs_pkg::RADIX_MIN) && (radix <= itrs_pkg::RADIX_MAX))
    else $error("radix register out of range");

  // never overwrite a character that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ((ctrl.op == itrs_pkg::OP_EMIT) || (ctrl.op == itrs_pkg::OP_SIGN)) |-> stat.out_free)
    else $error("output register overwritten");

endmodule
